>>> rtl/tcsc_pkg.sv
// Shared types, mode codes and character helpers for the text code stream converter.
package tcsc_pkg;

    localparam logic [2:0] MODE_IDENT   = 3'd0;
    localparam logic [2:0] MODE_ROT13   = 3'd1;
    localparam logic [2:0] MODE_TO_BIN  = 3'd2;
    localparam logic [2:0] MODE_TO_HEX  = 3'd3;
    localparam logic [2:0] MODE_FROM_BIN = 3'd4;
    localparam logic [2:0] MODE_FROM_HEX = 3'd5;
    localparam logic [2:0] MODE_LOWER   = 3'd6;
    localparam logic [2:0] MODE_UPPER   = 3'd7;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_ONE  = 8'h31;
    localparam logic [7:0] ROT_SHIFT = 8'd13;
    localparam logic [7:0] CASE_BIT  = 8'h20;

    typedef struct packed {
        logic [7:0] in_char;
        logic       in_final;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       out_final;
        logic       out_fault;
    } out_item_t;

    // How a converted transaction expands into result transactions
    typedef enum logic [1:0] {
        KIND_SINGLE = 2'd0,
        KIND_BIN8   = 2'd1,
        KIND_HEX2   = 2'd2
    } burst_kind_t;

    typedef struct packed {
        burst_kind_t kind;
        logic [7:0]  data;
        logic        final_flag;
        logic        fault;
    } burst_t;

    function automatic logic [7:0] rot13(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if ((c inside {[8'h41:8'h4d]}) || (c inside {[8'h61:8'h6d]}))
            r = c + ROT_SHIFT;
        else if ((c inside {[8'h4e:8'h5a]}) || (c inside {[8'h6e:8'h7a]}))
            r = c - ROT_SHIFT;
        return r;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c inside {[8'h41:8'h5a]}) ? (c | CASE_BIT) : c;
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c inside {[8'h61:8'h7a]}) ? (c & ~CASE_BIT) : c;
    endfunction

    // {valid, value}
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c inside {[8'h30:8'h39]})
            r = {1'b1, c[3:0]};
        else if ((c inside {[8'h41:8'h46]}) || (c inside {[8'h61:8'h66]}))
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? (CHAR_ZERO + {4'd0, n}) : (8'h57 + {4'd0, n});
    endfunction

endpackage

>>> rtl/tcsc_convert.sv
// Mode register, record state and per-transaction conversion into a result burst.
module tcsc_convert
    import tcsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       mode_wr_en,
    input  logic [2:0] mode_wr_data,
    input  logic       in_accept,
    input  in_item_t   in_item,
    output logic       burst_valid,
    output burst_t     burst
);

    logic [2:0] mode_reg;
    logic [7:0] bit_accum_reg,      bit_accum_next;
    logic [2:0] bit_count_reg,      bit_count_next;
    logic [3:0] high_nibble_reg,    high_nibble_next;
    logic       nibble_pending_reg, nibble_pending_next;
    logic       discarding_reg,     discarding_next;

    logic [7:0] c;
    logic       fin;
    logic [4:0] hv;
    logic [7:0] acc_shift;
    logic [2:0] cnt_inc;
    logic       fail;

    assign c         = in_item.in_char;
    assign fin       = in_item.in_final;
    assign hv        = hex_value(c);
    assign acc_shift = {bit_accum_reg[6:0], c == CHAR_ONE};
    assign cnt_inc   = bit_count_reg + 3'd1;

    always_comb
    begin
        bit_accum_next      = bit_accum_reg;
        bit_count_next      = bit_count_reg;
        high_nibble_next    = high_nibble_reg;
        nibble_pending_next = nibble_pending_reg;
        discarding_next     = discarding_reg;
        burst_valid         = 1'b0;
        burst.kind          = KIND_SINGLE;
        burst.data          = c;
        burst.final_flag    = fin;
        burst.fault         = 1'b0;
        fail                = 1'b0;

        if (discarding_reg)
        begin
            if (fin)
                discarding_next = 1'b0;
        end
        else
        begin
            case (mode_reg)
                MODE_ROT13:
                begin
                    burst_valid = 1'b1;
                    burst.data  = rot13(c);
                end
                MODE_TO_BIN:
                begin
                    burst_valid = 1'b1;
                    burst.kind  = KIND_BIN8;
                end
                MODE_TO_HEX:
                begin
                    burst_valid = 1'b1;
                    burst.kind  = KIND_HEX2;
                end
                MODE_FROM_BIN:
                begin
                    if (c != CHAR_ZERO && c != CHAR_ONE)
                        fail = 1'b1;
                    else if (cnt_inc == 3'd0 || fin)
                    begin
                        burst_valid    = 1'b1;
                        burst.data     = acc_shift;
                        bit_accum_next = 8'd0;
                        bit_count_next = 3'd0;
                    end
                    else
                    begin
                        bit_accum_next = acc_shift;
                        bit_count_next = cnt_inc;
                    end
                end
                MODE_FROM_HEX:
                begin
                    if (!hv[4])
                        fail = 1'b1;
                    else if (!nibble_pending_reg)
                    begin
                        if (fin)
                            fail = 1'b1;
                        else
                        begin
                            high_nibble_next    = hv[3:0];
                            nibble_pending_next = 1'b1;
                        end
                    end
                    else
                    begin
                        burst_valid         = 1'b1;
                        burst.data          = {high_nibble_reg, hv[3:0]};
                        high_nibble_next    = 4'd0;
                        nibble_pending_next = 1'b0;
                    end
                end
                MODE_LOWER:
                begin
                    burst_valid = 1'b1;
                    burst.data  = to_lower(c);
                end
                MODE_UPPER:
                begin
                    burst_valid = 1'b1;
                    burst.data  = to_upper(c);
                end
                default:
                    burst_valid = 1'b1;
            endcase

            if (fail)
            begin
                // error: one faulted result, drop the rest of the record
                burst_valid         = 1'b1;
                burst.kind          = KIND_SINGLE;
                burst.data          = 8'd0;
                burst.final_flag    = 1'b1;
                burst.fault         = 1'b1;
                bit_accum_next      = 8'd0;
                bit_count_next      = 3'd0;
                high_nibble_next    = 4'd0;
                nibble_pending_next = 1'b0;
                discarding_next     = !fin;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= MODE_IDENT;
            bit_accum_reg      <= 8'd0;
            bit_count_reg      <= 3'd0;
            high_nibble_reg    <= 4'd0;
            nibble_pending_reg <= 1'b0;
            discarding_reg     <= 1'b0;
        end
        else if (mode_wr_en)
        begin
            mode_reg           <= mode_wr_data;
            bit_accum_reg      <= 8'd0;
            bit_count_reg      <= 3'd0;
            high_nibble_reg    <= 4'd0;
            nibble_pending_reg <= 1'b0;
            discarding_reg     <= 1'b0;
        end
        else if (in_accept)
        begin
            bit_accum_reg      <= bit_accum_next;
            bit_count_reg      <= bit_count_next;
            high_nibble_reg    <= high_nibble_next;
            nibble_pending_reg <= nibble_pending_next;
            discarding_reg     <= discarding_next;
        end
    end

endmodule

>>> rtl/tcsc_emit.sv
// Burst holding register and result register; expands a burst into result transactions.
module tcsc_emit
    import tcsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      burst_load,
    input  burst_t    burst_in,
    output logic      burst_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic      burst_valid_reg, burst_valid_next;
    burst_t    burst_reg;
    logic [2:0] idx_reg, idx_next;
    logic      out_valid_reg, out_valid_next;
    out_item_t out_reg;

    logic      out_free;
    logic      last_piece;
    logic      advance;
    out_item_t piece;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        piece.out_fault = burst_reg.fault;
        case (burst_reg.kind)
            KIND_BIN8:
            begin
                last_piece     = (idx_reg == 3'd7);
                piece.out_char = burst_reg.data[3'd7 - idx_reg] ? CHAR_ONE : CHAR_ZERO;
            end
            KIND_HEX2:
            begin
                last_piece     = (idx_reg == 3'd1);
                piece.out_char = idx_reg[0] ? hex_char(burst_reg.data[3:0])
                                            : hex_char(burst_reg.data[7:4]);
            end
            default:
            begin
                last_piece     = 1'b1;
                piece.out_char = burst_reg.data;
            end
        endcase
        piece.out_final = burst_reg.final_flag && last_piece;
    end

    assign advance     = burst_valid_reg && out_free;
    assign burst_ready = !burst_valid_reg || (advance && last_piece);

    always_comb
    begin
        burst_valid_next = burst_valid_reg;
        idx_next         = idx_reg;
        if (advance)
        begin
            if (last_piece)
            begin
                burst_valid_next = 1'b0;
                idx_next         = 3'd0;
            end
            else
                idx_next = idx_reg + 3'd1;
        end
        if (burst_load)
            burst_valid_next = 1'b1;
        out_valid_next = advance ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_valid_reg <= 1'b0;
            idx_reg         <= 3'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            burst_valid_reg <= burst_valid_next;
            idx_reg         <= idx_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (burst_load)
            burst_reg <= burst_in;
        if (advance)
            out_reg <= piece;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // piece index only runs while a burst is held
    a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !burst_valid_reg |-> idx_reg == 3'd0)
        else $error("piece index non-zero with no burst held");

    a_idx_single: assert property (@(posedge clk) disable iff (!rst_n)
        burst_valid_reg && burst_reg.kind == KIND_SINGLE |-> idx_reg == 3'd0)
        else $error("single burst with non-zero piece index");

    a_idx_hex: assert property (@(posedge clk) disable iff (!rst_n)
        burst_valid_reg && burst_reg.kind == KIND_HEX2 |-> idx_reg <= 3'd1)
        else $error("hex burst past its second piece");

    a_fault_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.out_fault |-> out_reg.out_final && out_reg.out_char == 8'd0)
        else $error("fault result not final or not zero");

endmodule

>>> rtl/text_code_stream_converter.sv
// Top level of the text code stream converter: record conversion and result expansion.
//
//  channel   direction  handshake            payload
//  in        input      in_valid / in_ready  in_data   (in_item_t)
//  out       output     out_valid/out_ready  out_data  (out_item_t)
//  mode cfg  input      mode_wr_en           mode_wr_data (3 bits, no wait)
//
// Each input transaction is converted combinationally, and one that yields a result
// is loaded into the held burst; the result register then issues one result
// transaction per cycle while the output is not stalled. Single-result modes sustain
// one transaction per cycle while the output is not stalled; byte-to-binary emits
// eight results and byte-to-hex two per input, all on the one result port.
// Reset (rst_n low, asynchronous) clears mode to identity and all record state.
// A stalled output holds the result register; the burst register stays full and
// in_ready drops until the last piece of the burst moves on.
module text_code_stream_converter
    import tcsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       mode_wr_en,
    input  logic [2:0] mode_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data
);

    logic   in_accept;
    logic   burst_valid;
    burst_t burst;
    logic   burst_ready;

    // an input transaction is taken whenever the burst register can take one,
    // even if the transaction ends up producing no result
    assign in_ready  = burst_ready;
    assign in_accept = in_valid && in_ready;

    tcsc_convert u_convert (
        .clk          (clk),
        .rst_n        (rst_n),
        .mode_wr_en   (mode_wr_en),
        .mode_wr_data (mode_wr_data),
        .in_accept    (in_accept),
        .in_item      (in_data),
        .burst_valid  (burst_valid),
        .burst        (burst)
    );

    tcsc_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst_load  (in_accept && burst_valid),
        .burst_in    (burst),
        .burst_ready (burst_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data)
    );

endmodule
